FILE: rtl/core/htm_pkg.sv
// Package for the host/target mailbox: shared types, constants and the
// enumeration string table. No dependencies.
`default_nettype none

package htm_pkg;

  localparam int CfgIdxW = 2;
  localparam int IdxW    = 4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TOHOST_OFS   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FROMHOST_OFS = 2'd1;

  // Request types
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_RX    = 2'd2;

  // Devices and commands
  localparam logic [7:0] DEV_SYS     = 8'h00;
  localparam logic [7:0] DEV_CONSOLE = 8'h01;
  localparam logic [7:0] DEV_NULL    = 8'h02;
  localparam logic [7:0] CMD_ZERO    = 8'h00;
  localparam logic [7:0] CMD_TX      = 8'h01;
  localparam logic [7:0] CMD_IDENT   = 8'hFF;

  localparam logic [15:0] RX_FLAG  = 16'h0100;
  localparam logic [15:0] TX_FLAG  = 16'h0100;
  localparam logic [47:0] PAYLOAD_MASK = 48'hFFFF_FFFF_FFFF;

  typedef enum logic {S_IDLE, S_OUT} state_t;

  typedef enum logic [2:0] {
    STR_NONE, STR_PROXY, STR_SYSCALL, STR_BCD, STR_READ, STR_WRITE, STR_END
  } str_id_t;

  // Controller to datapath
  typedef struct packed {
    logic            load;
    logic [IdxW-1:0] idx;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [IdxW-1:0] last_idx;
  } sts_t;

  // Index of the final result (terminator) for a string
  function automatic logic [IdxW-1:0] str_last(input str_id_t id);
    logic [IdxW-1:0] n;
    case (id)
      STR_PROXY:   n = 4'd13;
      STR_SYSCALL: n = 4'd7;
      STR_BCD:     n = 4'd3;
      STR_READ:    n = 4'd4;
      STR_WRITE:   n = 4'd5;
      default:     n = 4'd0;
    endcase
    return n;
  endfunction

  // Byte k of a string, zero at and past its terminator
  function automatic logic [7:0] str_byte(input str_id_t id, input logic [IdxW-1:0] k);
    logic [111:0] s;
    case (id)
      STR_PROXY:   s = {"syscall", "_proxy", 8'h00};
      STR_SYSCALL: s = {"syscall", 56'h0};
      STR_BCD:     s = {"bcd", 88'h0};
      STR_READ:    s = {"read", 80'h0};
      STR_WRITE:   s = {"write", 72'h0};
      default:     s = '0;
    endcase
    if (k > 4'd13) begin
      return 8'h00;
    end
    return s[8*(4'd13 - k) +: 8];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/htm_ctrl.sv
// Controller for the host/target mailbox: accepts one item, then walks the
// result index until the last result is taken. Uses htm_pkg.
`default_nettype none

module htm_ctrl import htm_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  output logic out_last,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t          state_r, state_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;

  // State and index registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = (idx_r == sts.last_idx);
    cmd.load  = 1'b0;
    cmd.idx   = idx_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (out_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/htm_dp.sv
// Datapath for the host/target mailbox: mailbox registers, offsets, command
// decode and the result registers. Uses htm_pkg.
`default_nettype none

module htm_dp import htm_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [CfgIdxW-1:0] cfg_index,
  input  wire  [31:0]        cfg_data,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  wire  [1:0]         req_type,
  input  wire  [31:0]        bus_offset,
  input  wire  [31:0]        write_data,
  input  wire  [7:0]         rx_byte,
  output logic [31:0]        read_data,
  output logic               irq_level,
  output logic               mem_write,
  output logic [40:0]        mem_address,
  output logic [7:0]         mem_byte,
  output logic               tx_valid,
  output logic [7:0]         tx_byte,
  output logic               exit_valid,
  output logic [46:0]        exit_status
);

  // Mailbox state
  logic [63:0] tohost_r, tohost_nxt;
  logic [63:0] fromhost_r, fromhost_nxt;
  logic [15:0] tag_r, tag_nxt;
  logic        allow_r, allow_nxt;
  logic        irq_r, irq_nxt;
  logic [31:0] to_ofs_r, from_ofs_r;

  // Result registers
  logic [31:0] rd_r, rd_nxt;
  logic        txv_r, txv_nxt;
  logic [7:0]  txb_r, txb_nxt;
  logic        exv_r, exv_nxt;
  logic [46:0] exc_r, exc_nxt;
  str_id_t     str_r, str_nxt;
  logic [39:0] base_r, base_nxt;

  // Offset matches; the +4 forms are 33 bits wide and never wrap
  logic        hit_tl, hit_th, hit_fl, hit_fh;
  logic [32:0] to_hi_ofs, from_hi_ofs;
  logic [63:0] full;
  logic [7:0]  dev, op, what;
  logic [47:0] payload;
  logic [15:0] resp;
  logic        finish;
  logic [63:0] fh_or;

  assign to_hi_ofs   = {1'b0, to_ofs_r} + 33'd4;
  assign from_hi_ofs = {1'b0, from_ofs_r} + 33'd4;
  assign hit_tl = (bus_offset == to_ofs_r);
  assign hit_th = ({1'b0, bus_offset} == to_hi_ofs);
  assign hit_fl = (bus_offset == from_ofs_r);
  assign hit_fh = ({1'b0, bus_offset} == from_hi_ofs);

  assign full    = tohost_r | {write_data, 32'h0};
  assign dev     = full[63:56];
  assign op      = full[55:48];
  assign payload = full[47:0] & PAYLOAD_MASK;
  assign what    = payload[7:0];
  assign fh_or   = fromhost_r | {write_data, 32'h0};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      to_ofs_r   <= 32'd0;
      from_ofs_r <= 32'd8;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TOHOST_OFS) begin
        to_ofs_r <= cfg_data;
      end else if (cfg_index == CFG_FROMHOST_OFS) begin
        from_ofs_r <= cfg_data;
      end
    end
  end

  // Decode one item and compute the next mailbox state
  always_comb begin
    tohost_nxt   = tohost_r;
    fromhost_nxt = fromhost_r;
    tag_nxt      = tag_r;
    allow_nxt    = allow_r;
    irq_nxt      = irq_r;
    rd_nxt       = '0;
    txv_nxt      = 1'b0;
    txb_nxt      = '0;
    exv_nxt      = 1'b0;
    exc_nxt      = '0;
    str_nxt      = STR_NONE;
    base_nxt     = '0;
    resp         = '0;
    finish       = 1'b1;
    case (req_type)
      REQ_READ: begin
        if (hit_tl) begin
          rd_nxt = tohost_r[31:0];
        end else if (hit_th) begin
          rd_nxt = tohost_r[63:32];
        end else if (hit_fl) begin
          rd_nxt = fromhost_r[31:0];
        end else if (hit_fh) begin
          rd_nxt = fromhost_r[63:32];
        end
      end
      REQ_WRITE: begin
        if (hit_tl) begin
          if (tohost_r == 64'h0) begin
            allow_nxt  = 1'b1;
            tohost_nxt = {32'h0, write_data};
          end else begin
            allow_nxt = 1'b0;
          end
        end else if (hit_th) begin
          if (allow_r) begin
            base_nxt = payload[47:8];
            if (dev == DEV_SYS) begin
              if (op == CMD_ZERO) begin
                if (payload[0]) begin
                  exv_nxt = 1'b1;
                  exc_nxt = payload[47:1];
                end
              end else if (op == CMD_IDENT) begin
                str_nxt = (what == 8'hFF) ? STR_PROXY :
                          (what == 8'h00) ? STR_SYSCALL : STR_END;
                resp    = 16'd1;
              end
            end else if (dev == DEV_CONSOLE) begin
              if (op == CMD_ZERO) begin
                tag_nxt = full[63:48];
                finish  = 1'b0;
              end else if (op == CMD_TX) begin
                txv_nxt = 1'b1;
                txb_nxt = what;
                resp    = TX_FLAG | {8'h0, what};
              end else if (op == CMD_IDENT) begin
                str_nxt = (what == 8'hFF) ? STR_BCD :
                          (what == 8'h00) ? STR_READ :
                          (what == 8'h01) ? STR_WRITE : STR_END;
                resp    = 16'd1;
              end
            end else if (dev == DEV_NULL && op == CMD_IDENT && what == 8'hFF) begin
              str_nxt = STR_END;
              resp    = 16'd1;
            end
            tohost_nxt = 64'h0;
            if (finish) begin
              fromhost_nxt = {full[63:48], 32'h0, resp};
              if ((full[63:48] != 16'h0) || (resp != 16'h0)) begin
                irq_nxt = 1'b1;
              end
            end
          end
        end else if (hit_fl) begin
          fromhost_nxt = {32'h0, write_data};
        end else if (hit_fh) begin
          fromhost_nxt = fh_or;
          if (fh_or == 64'h0) begin
            irq_nxt = 1'b0;
          end
        end
      end
      REQ_RX: begin
        fromhost_nxt = {tag_r, 32'h0, RX_FLAG | {8'h0, rx_byte}};
        irq_nxt      = 1'b1;
      end
      default: ;
    endcase
  end

  // Mailbox state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tohost_r   <= '0;
      fromhost_r <= '0;
      tag_r      <= '0;
      allow_r    <= 1'b0;
      irq_r      <= 1'b0;
      str_r      <= STR_NONE;
    end else if (cmd.load) begin
      tohost_r   <= tohost_nxt;
      fromhost_r <= fromhost_nxt;
      tag_r      <= tag_nxt;
      allow_r    <= allow_nxt;
      irq_r      <= irq_nxt;
      str_r      <= str_nxt;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_r   <= rd_nxt;
      txv_r  <= txv_nxt;
      txb_r  <= txb_nxt;
      exv_r  <= exv_nxt;
      exc_r  <= exc_nxt;
      base_r <= base_nxt;
    end
  end

  // Drive the result selected by the controller's index
  assign sts.last_idx = str_last(str_r);
  assign read_data    = rd_r;
  assign irq_level    = irq_r;
  assign mem_write    = (str_r != STR_NONE);
  assign mem_address  = mem_write ? ({1'b0, base_r} + {{(41-IdxW){1'b0}}, cmd.idx}) : 41'h0;
  assign mem_byte     = str_byte(str_r, cmd.idx);
  assign tx_valid     = txv_r;
  assign tx_byte      = txb_r;
  assign exit_valid   = exv_r;
  assign exit_status  = exc_r;

endmodule

`default_nettype wire

FILE: rtl/core/host_target_mailbox.sv
// Host/target mailbox top level: controller, datapath and checks.
// The first result is valid in the cycle after an item is accepted.
// An item gives 1 result, or up to 14 for a name enumeration (one string byte
// per cycle while out_ready is high, set by the result index counter).
// Reset (rst_n low, synchronous): mailbox words, tag, allow and interrupt clear;
// tohost offset returns to 0 and fromhost offset to 8. Uses htm_pkg.
`default_nettype none

module host_target_mailbox import htm_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [CfgIdxW-1:0] cfg_index,
  input  wire  [31:0]        cfg_data,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [1:0]         in_req_type,
  input  wire  [31:0]        in_bus_offset,
  input  wire  [31:0]        in_write_data,
  input  wire  [7:0]         in_rx_byte,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [31:0]        out_read_data,
  output logic               out_irq_level,
  output logic               out_mem_write,
  output logic [40:0]        out_mem_address,
  output logic [7:0]         out_mem_byte,
  output logic               out_tx_valid,
  output logic [7:0]         out_tx_byte,
  output logic               out_exit_valid,
  output logic [46:0]        out_exit_status,
  output logic               out_last
);

  cmd_t cmd;
  sts_t sts;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  htm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_last  (out_last),
    .cmd       (cmd),
    .sts       (sts)
  );

  htm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (in_req_type),
    .bus_offset  (in_bus_offset),
    .write_data  (in_write_data),
    .rx_byte     (in_rx_byte),
    .read_data   (out_read_data),
    .irq_level   (out_irq_level),
    .mem_write   (out_mem_write),
    .mem_address (out_mem_address),
    .mem_byte    (out_mem_byte),
    .tx_valid    (out_tx_valid),
    .tx_byte     (out_tx_byte),
    .exit_valid  (out_exit_valid),
    .exit_status (out_exit_status)
  );

  // One item in flight: never take input while results are pending
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while results pending");

  // Final result ends the item
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("results continue after last");

  // Only enumeration items produce more than one result
  a_multi_enum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> out_mem_write)
    else $error("multiple results without memory write");

  // Memory fields are zero when no memory write is carried
  a_mem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_mem_write) |-> (out_mem_address == 41'h0 && out_mem_byte == 8'h0))
    else $error("memory fields set without memory write");

endmodule

`default_nettype wire

FILE: dv/host_target_mailbox_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the host/target mailbox: directed and random bus
// traffic, console input and offset settings, checked against a built-in model.
// Depends on htm_pkg and host_target_mailbox.

module host_target_mailbox_tb;
  import htm_pkg::*;

  // Request type with no effect, spare register index, enumeration selectors
  localparam logic [1:0]         REQ_NONE   = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPARE  = 2'd2;
  localparam logic [7:0]         SEL_ALL    = 8'hFF;
  localparam logic [7:0]         SEL_FIRST  = 8'h00;
  localparam logic [7:0]         SEL_SECOND = 8'h01;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
    logic        mem_write;
    logic [40:0] mem_address;
    logic [7:0]  mem_byte;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        exit_valid;
    logic [46:0] exit_status;
    logic        last;
  } mbox_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_req_type = REQ_READ;
  logic [31:0]        in_bus_offset = '0;
  logic [31:0]        in_write_data = '0;
  logic [7:0]         in_rx_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [31:0]        out_read_data;
  logic               out_irq_level;
  logic               out_mem_write;
  logic [40:0]        out_mem_address;
  logic [7:0]         out_mem_byte;
  logic               out_tx_valid;
  logic [7:0]         out_tx_byte;
  logic               out_exit_valid;
  logic [46:0]        out_exit_status;
  logic               out_last;

  // Mailbox model state and offsets, at their reset values
  logic [63:0] mb_tohost   = '0;
  logic [63:0] mb_fromhost = '0;
  logic [15:0] mb_read_tag = '0;
  logic        mb_allow_hi = 1'b0;
  logic        mb_irq      = 1'b0;
  logic [31:0] mb_th_ofs   = 32'h0;
  logic [31:0] mb_fh_ofs   = 32'h8;

  mbox_result_t mbox_expect_q[$];
  mbox_result_t head_r;

  int error_count     = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int name_bytes      = 0;
  int exits_seen      = 0;
  int settings_used   = 0;
  int burst_left      = 0;
  int idle_cycles     = 0;
  int ready_hold      = 0;
  logic [9:0] tb_cycle = '0;

  host_target_mailbox u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_bus_offset   (in_bus_offset),
    .in_write_data   (in_write_data),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data),
    .out_irq_level   (out_irq_level),
    .out_mem_write   (out_mem_write),
    .out_mem_address (out_mem_address),
    .out_mem_byte    (out_mem_byte),
    .out_tx_valid    (out_tx_valid),
    .out_tx_byte     (out_tx_byte),
    .out_exit_valid  (out_exit_valid),
    .out_exit_status (out_exit_status),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the mailbox model by one item and queue the results it causes
  task automatic predict_mailbox(input logic [1:0] req, input logic [31:0] ofs,
                                 input logic [31:0] wd, input logic [7:0] rx);
    logic [31:0]  rd;
    logic [32:0]  ofs_w, th_hi_ofs, fh_hi_ofs;
    logic [63:0]  cmd_word, resp;
    logic [7:0]   dev, op, sel, tx_b;
    logic [47:0]  pl;
    logic         tx_v, ex_v, has_name, keep_fh;
    logic [46:0]  ex_c;
    logic [40:0]  base, kk;
    string        name;
    int           n, k;
    mbox_result_t r;
    rd = '0;
    tx_v = 1'b0;
    tx_b = '0;
    ex_v = 1'b0;
    ex_c = '0;
    has_name = 1'b0;
    keep_fh = 1'b0;
    name = "";
    base = '0;
    resp = '0;
    ofs_w = {1'b0, ofs};
    // High halves sit at offset + 4, formed one bit wider so they never wrap
    th_hi_ofs = {1'b0, mb_th_ofs} + 33'd4;
    fh_hi_ofs = {1'b0, mb_fh_ofs} + 33'd4;
    case (req)
      REQ_READ: begin
        if (ofs == mb_th_ofs) rd = mb_tohost[31:0];
        else if (ofs_w == th_hi_ofs) rd = mb_tohost[63:32];
        else if (ofs == mb_fh_ofs) rd = mb_fromhost[31:0];
        else if (ofs_w == fh_hi_ofs) rd = mb_fromhost[63:32];
      end
      REQ_WRITE: begin
        if (ofs == mb_th_ofs) begin
          // Low half is taken only while tohost is empty
          if (mb_tohost == 64'h0) begin
            mb_allow_hi = 1'b1;
            mb_tohost = {32'h0, wd};
          end else begin
            mb_allow_hi = 1'b0;
          end
        end else if (ofs_w == th_hi_ofs) begin
          if (mb_allow_hi) begin
            mb_tohost[63:32] = mb_tohost[63:32] | wd;
            cmd_word = mb_tohost;
            dev = cmd_word[63:56];
            op = cmd_word[55:48];
            pl = cmd_word[47:0];
            sel = pl[7:0];
            base = {1'b0, pl[47:8]};
            if (dev == DEV_SYS) begin
              if (op == CMD_ZERO) begin
                if (pl[0]) begin
                  ex_v = 1'b1;
                  ex_c = pl[47:1];
                end
              end else if (op == CMD_IDENT) begin
                has_name = 1'b1;
                resp = 64'd1;
                if (sel == SEL_ALL) name = $sformatf("%s_%s", "syscall", "proxy");
                else if (sel == SEL_FIRST) name = "syscall";
              end
            end else if (dev == DEV_CONSOLE) begin
              if (op == CMD_ZERO) begin
                // Console read records the tag and clears tohost; fromhost is untouched
                mb_read_tag = cmd_word[63:48];
                mb_tohost = '0;
                keep_fh = 1'b1;
              end else if (op == CMD_TX) begin
                tx_v = 1'b1;
                tx_b = sel;
                resp = {48'h0, TX_FLAG} | {56'h0, sel};
              end else if (op == CMD_IDENT) begin
                has_name = 1'b1;
                resp = 64'd1;
                if (sel == SEL_ALL) name = "bcd";
                else if (sel == SEL_FIRST) name = "read";
                else if (sel == SEL_SECOND) name = "write";
              end
            end else if (dev == DEV_NULL && op == CMD_IDENT && sel == SEL_ALL) begin
              has_name = 1'b1;
              resp = 64'd1;
            end
            if (!keep_fh) begin
              mb_fromhost = {cmd_word[63:48], 48'h0} | resp;
              mb_tohost = '0;
              if (mb_fromhost != 64'h0) mb_irq = 1'b1;
            end
          end
        end else if (ofs == mb_fh_ofs) begin
          mb_fromhost = {32'h0, wd};
        end else if (ofs_w == fh_hi_ofs) begin
          mb_fromhost[63:32] = mb_fromhost[63:32] | wd;
          if (mb_fromhost == 64'h0) mb_irq = 1'b0;
        end
      end
      REQ_RX: begin
        mb_fromhost = {mb_read_tag, 48'h0} | {48'h0, RX_FLAG} | {56'h0, rx};
        mb_irq = 1'b1;
      end
      default: ;
    endcase
    // One result per string byte plus terminator, else a single result
    n = has_name ? name.len() + 1 : 1;
    for (k = 0; k < n; k++) begin
      kk = 41'(k);
      r.read_data = rd;
      r.irq_level = mb_irq;
      r.mem_write = has_name;
      r.mem_address = has_name ? base + kk : '0;
      r.mem_byte = (has_name && k < name.len()) ? name[k] : 8'h00;
      r.tx_valid = tx_v;
      r.tx_byte = tx_b;
      r.exit_valid = ex_v;
      r.exit_status = ex_c;
      r.last = (k == n - 1);
      mbox_expect_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic check_field(input string fname, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h (result %0d)",
                                fname, got, want, results_checked));
    end
  endtask

  // Send one item; the sender works in bursts with random gaps between them
  task automatic send_item(input logic [1:0] req, input logic [31:0] ofs,
                           input logic [31:0] wd, input logic [7:0] rx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req_type <= req;
    in_bus_offset <= ofs;
    in_write_data <= wd;
    in_rx_byte <= rx;
    do @(posedge clk); while (!in_ready);
    predict_mailbox(req, ofs, wd, rx);
    items_sent++;
  endtask

  // Post a 64-bit command: low half only while tohost is empty, then high half
  task automatic send_command(input logic [63:0] word);
    if (mb_tohost == 64'h0) send_item(REQ_WRITE, mb_th_ofs, word[31:0], 8'($urandom));
    send_item(REQ_WRITE, mb_th_ofs + 32'd4, word[63:32], 8'($urandom));
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TOHOST_OFS) mb_th_ofs = data;
    else if (idx == CFG_FROMHOST_OFS) mb_fh_ofs = data;
  endtask

  task automatic configure(input logic [31:0] th, input logic [31:0] fh,
                           input logic touch_spare);
    cfg_write(CFG_TOHOST_OFS, th);
    cfg_write(CFG_FROMHOST_OFS, fh);
    if (touch_spare) cfg_write(CFG_SPARE, $urandom);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Hold off the sender and drain every outstanding result
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (mbox_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_register_reads();
    send_item(REQ_READ, mb_th_ofs, 32'h0, 8'h0);
    send_item(REQ_READ, mb_th_ofs + 32'd4, 32'h0, 8'h0);
    send_item(REQ_READ, mb_fh_ofs, 32'h0, 8'h0);
    send_item(REQ_READ, mb_fh_ofs + 32'd4, 32'h0, 8'h0);
    send_item(REQ_READ, 32'hFFFF_FFFF, 32'h0, 8'h0);
    send_item(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
  endtask

  task automatic test_console_receive();
    send_item(REQ_RX, 32'h0, 32'h0, 8'h00);
    send_item(REQ_RX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(REQ_READ, mb_fh_ofs, 32'h0, 8'h0);
  endtask

  // Clearing fromhost through its high half drops the interrupt
  task automatic test_fromhost_clear();
    send_item(REQ_WRITE, mb_fh_ofs + 32'd4, 32'h0, 8'h0);
    send_item(REQ_WRITE, mb_fh_ofs, 32'h0, 8'h0);
    send_item(REQ_WRITE, mb_fh_ofs + 32'd4, 32'h0, 8'h0);
    send_item(REQ_WRITE, mb_fh_ofs + 32'd4, 32'hFFFF_FFFF, 8'h0);
    send_item(REQ_READ, mb_fh_ofs + 32'd4, 32'h0, 8'h0);
  endtask

  task automatic test_commands();
    send_command({DEV_SYS, CMD_ZERO, 48'hFFFF_FFFF_FFFF});
    send_command({DEV_CONSOLE, CMD_ZERO, 48'h0});
    send_item(REQ_RX, 32'h0, 32'h0, 8'h5A);
    send_command({DEV_CONSOLE, CMD_TX, 40'h0, 8'hA5});
    send_command({DEV_SYS, CMD_IDENT, 48'hFFFF_FFFF_FFFF});
    // Allow stays set after a command: a lone high write runs another one
    send_item(REQ_WRITE, mb_th_ofs + 32'd4, {DEV_CONSOLE, CMD_IDENT, 16'h0}, 8'h0);
    send_item(REQ_WRITE, mb_th_ofs + 32'd4, {8'hFF, CMD_IDENT, 16'h0}, 8'h0);
  endtask

  // Random commands, mostly well-formed, plus reads, console input, fromhost writes and noise
  task automatic test_random_traffic(input int count);
    int          pick, r;
    logic [7:0]  dev, op, sel;
    logic [63:0] word;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        r = $urandom_range(0, 19);
        if (r < 7) dev = DEV_SYS;
        else if (r < 15) dev = DEV_CONSOLE;
        else if (r < 17) dev = DEV_NULL;
        else dev = 8'($urandom);
        r = $urandom_range(0, 9);
        if (r < 4) op = CMD_IDENT;
        else if (r < 7) op = (dev == DEV_CONSOLE) ? CMD_TX : CMD_ZERO;
        else if (r < 9) op = CMD_ZERO;
        else op = 8'($urandom);
        r = $urandom_range(0, 9);
        if (r < 4) sel = SEL_ALL;
        else if (r < 6) sel = SEL_FIRST;
        else if (r < 8) sel = SEL_SECOND;
        else sel = 8'($urandom);
        word = {$urandom, $urandom};
        word[63:56] = dev;
        word[55:48] = op;
        word[7:0] = sel;
        send_command(word);
      end else if (pick < 52) begin
        send_item(REQ_WRITE, mb_th_ofs + 32'd4, $urandom, 8'($urandom));
      end else if (pick < 67) begin
        case ($urandom_range(0, 4))
          0: word[31:0] = mb_th_ofs;
          1: word[31:0] = mb_th_ofs + 32'd4;
          2: word[31:0] = mb_fh_ofs;
          3: word[31:0] = mb_fh_ofs + 32'd4;
          default: word[31:0] = $urandom;
        endcase
        send_item(REQ_READ, word[31:0], $urandom, 8'($urandom));
      end else if (pick < 77) begin
        send_item(REQ_RX, $urandom, $urandom, 8'($urandom));
      end else if (pick < 87) begin
        word[31:0] = ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom;
        send_item(REQ_WRITE, $urandom_range(0, 1) ? mb_fh_ofs : mb_fh_ofs + 32'd4,
                  word[31:0], 8'($urandom));
      end else if (pick < 94) begin
        send_item(2'($urandom_range(0, 3)), $urandom, $urandom, 8'($urandom));
      end else begin
        send_item(REQ_NONE, $urandom, $urandom, 8'($urandom));
      end
    end
  endtask

  // A low write into a busy tohost is dropped and blocks the high half
  task automatic test_busy_drop();
    send_item(REQ_WRITE, mb_th_ofs, 32'h0000_1234, 8'h0);
    send_item(REQ_WRITE, mb_th_ofs, 32'h0000_5678, 8'h0);
    send_item(REQ_WRITE, mb_th_ofs + 32'd4, {DEV_CONSOLE, CMD_TX, 16'h0}, 8'h0);
    send_item(REQ_READ, mb_th_ofs, 32'h0, 8'h0);
    send_item(REQ_READ, mb_th_ofs + 32'd4, 32'h0, 8'h0);
    send_item(REQ_RX, 32'h0, 32'h0, 8'($urandom));
  endtask

  // Receiver: stretches with no stall, and stretches with short random stalls
  always @(posedge clk) begin
    tb_cycle <= tb_cycle + 10'd1;
    if (ready_hold != 0) begin
      out_ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (tb_cycle[6] && $urandom_range(0, 2) == 0) ready_hold <= $urandom_range(1, 5);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (mbox_expect_q.size() == 0) begin
        report_mismatch($sformatf("result with none expected, read_data %0h",
                                  out_read_data));
      end else begin
        head_r = mbox_expect_q.pop_front();
        check_field("read_data", 64'(out_read_data), 64'(head_r.read_data));
        check_field("irq_level", 64'(out_irq_level), 64'(head_r.irq_level));
        check_field("mem_write", 64'(out_mem_write), 64'(head_r.mem_write));
        check_field("mem_address", 64'(out_mem_address), 64'(head_r.mem_address));
        check_field("mem_byte", 64'(out_mem_byte), 64'(head_r.mem_byte));
        check_field("tx_valid", 64'(out_tx_valid), 64'(head_r.tx_valid));
        check_field("tx_byte", 64'(out_tx_byte), 64'(head_r.tx_byte));
        check_field("exit_valid", 64'(out_exit_valid), 64'(head_r.exit_valid));
        check_field("exit_status", 64'(out_exit_status), 64'(head_r.exit_status));
        check_field("last", 64'(out_last), 64'(head_r.last));
        if (head_r.mem_write) name_bytes++;
        if (head_r.exit_valid) exits_seen++;
        results_checked++;
      end
    end
  end

  // Watchdog: end the run when no handshake happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, mbox_expect_q.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    configure(32'h0000_0000, 32'h0000_0008, 1'b0);
    test_register_reads();
    test_console_receive();
    test_fromhost_clear();
    test_commands();

    wait_idle();
    configure(32'h0000_1000, 32'h0000_1010, 1'b0);
    test_random_traffic(20);

    // Tohost high half lies past the top of the offset space
    wait_idle();
    configure(32'hFFFF_FFFC, 32'hFFFF_FFF0, 1'b1);
    test_random_traffic(12);

    // Fromhost low half shadowed by the tohost high half
    wait_idle();
    configure(32'h0000_0040, 32'h0000_0044, 1'b0);
    test_random_traffic(12);

    wait_idle();
    configure(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    test_random_traffic(12);

    wait_idle();
    configure($urandom & 32'hFFFF_FFF0, $urandom & 32'hFFFF_FFF0 | 32'h0000_0008, 1'b0);
    test_random_traffic(12);
    test_busy_drop();

    wait_idle();
    $display("Run covered %0d items across %0d offset settings, %0d results checked",
             items_sent, settings_used, results_checked);
    $display("  with %0d name-string bytes, %0d exit requests, %0d mismatches",
             name_bytes, exits_seen, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
